@@ sv/spik_pkg.sv @@
// ============================================================================
// spik_pkg
// Shared types, constants and helper functions for the Stewart platform
// inverse kinematics block.
// ============================================================================
package spik_pkg;

  localparam int NUM_STRUTS     = 6;
  localparam int NUM_REGS       = 7;
  localparam int POSE_FRAC_BITS = 16;

  // Pose conversion to 16 fraction bits
  localparam int Q16_UP = (POSE_FRAC_BITS < 16) ? 16 - POSE_FRAC_BITS : 0;
  localparam int Q16_DN = (POSE_FRAC_BITS > 16) ? POSE_FRAC_BITS - 16 : 0;
  localparam int POS_W  = 32 + Q16_UP;
  localparam int ANG_W  = 25 + Q16_UP;

  localparam int CDEG_W       = 33;  // degrees, 16 fraction bits, into CORDIC
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int TRIG_W       = 32;
  localparam int MUL_W        = 34;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int R_W          = 34;
  localparam int D_W          = POS_W + 4;
  localparam int JOINT_DEPTH  = 4 * NUM_STRUTS;
  localparam int JOINT_AW     = $clog2(JOINT_DEPTH);
  localparam int STRUT_W      = $clog2(NUM_STRUTS);
  localparam int REG_IDX_W    = 3;
  localparam int CFG_W        = 48;
  localparam int SCALE_W      = 24;

  localparam logic [31:0]                DEG_TO_TURN = 32'd3054198966;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K    = 34'sd652032874;

  localparam logic [19:0]      BASE_RADIUS_RST = 20'd38400;
  localparam logic [19:0]      PLAT_RADIUS_RST = 20'd25600;
  localparam logic [13:0]      HALF_ANGLE_RST  = 14'd3840;
  localparam logic [CFG_W-1:0] SCALE_RST       = 48'd343597404160;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE_RADIUS = 3'd0,
    REG_PLAT_RADIUS = 3'd1,
    REG_BASE_HALF   = 3'd2,
    REG_PLAT_HALF   = 3'd3,
    REG_SCALE_A     = 3'd4,
    REG_SCALE_B     = 3'd5,
    REG_SCALE_C     = 3'd6
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_JANG,
    ST_JWAIT,
    ST_JMC,
    ST_JWC,
    ST_JWS,
    ST_IDLE,
    ST_PANG,
    ST_PWAIT,
    ST_PMAT,
    ST_SRD,
    ST_SPROD,
    ST_SSQ,
    ST_SQGO,
    ST_SQWAIT,
    ST_SCALE,
    ST_STEP,
    ST_DONE
  } spik_state_e;

  // atan(2^-i) as a fraction of a full turn (2^32)
  function automatic logic [31:0] turn_atan(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Pair center angle in degrees with 16 fraction bits
  function automatic logic signed [CDEG_W-1:0] pair_deg(input logic [1:0] pair,
                                                        input logic plat);
    int d;
    unique case (pair)
      2'd0:    d = plat ? 60 : 0;
      2'd1:    d = plat ? 180 : 120;
      2'd2:    d = plat ? 300 : 240;
      default: d = 0;
    endcase
    return CDEG_W'(d * 65536);
  endfunction

  function automatic logic signed [POS_W-1:0] pos_to_q16(input logic signed [31:0] v);
    logic signed [POS_W:0] e;
    e = (POS_W+1)'(v);
    if (Q16_DN > 0) e = (e + (POS_W+1)'((1 << Q16_DN) >> 1)) >>> Q16_DN;
    else            e = e <<< Q16_UP;
    return e[POS_W-1:0];
  endfunction

  function automatic logic signed [ANG_W-1:0] ang_to_q16(input logic signed [24:0] v);
    logic signed [ANG_W:0] e;
    e = (ANG_W+1)'(v);
    if (Q16_DN > 0) e = (e + (ANG_W+1)'((1 << Q16_DN) >> 1)) >>> Q16_DN;
    else            e = e <<< Q16_UP;
    return e[ANG_W-1:0];
  endfunction

endpackage

@@ sv/spik_joint_mem.sv @@
// ============================================================================
// spik_joint_mem
// Joint coordinate table: base x/y and platform x/y for each strut.
// One write port, one read port, registered read data.
// ============================================================================
module spik_joint_mem import spik_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [JOINT_AW-1:0] waddr_i,
  input  logic [31:0]         wdata_i,
  input  logic [JOINT_AW-1:0] raddr_i,
  output logic [31:0]         rdata_o
);

  logic [31:0] mem_q [JOINT_DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/spik_cordic.sv @@
// ============================================================================
// spik_cordic
// Iterative sine/cosine: degrees to binary angle, quadrant fold, then one
// rotation step per cycle.
// ============================================================================
module spik_cordic import spik_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CDEG_W-1:0] deg_i,
  output logic                     done_o,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic                       load_q, run_q, done_q;
  logic [4:0]                 it_q;
  logic signed [2*CDEG_W-1:0] prod_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  logic signed [CORDIC_W-1:0] x_n, y_n, z_n, x_sh, y_sh, atan_s;
  logic signed [TRIG_W-1:0]   cos_q, sin_q;
  logic                       flip_q, flip_d;
  logic [55:0]                turn_sum;
  logic [31:0]                turn, turn_f;

  assign turn_sum = prod_q[55:0] + 56'h80_0000;
  assign turn     = turn_sum[55:24];
  // second and third quadrant: rotate by half a turn, negate at the end
  assign flip_d   = turn[31] ^ turn[30];
  assign turn_f   = {turn[31] ^ flip_d, turn[30:0]};

  assign x_sh   = x_q >>> it_q;
  assign y_sh   = y_q >>> it_q;
  assign atan_s = $signed({2'b00, turn_atan(it_q)});

  always_comb begin
    if (!z_q[CORDIC_W-1]) begin
      x_n = x_q - y_sh;
      y_n = y_q + x_sh;
      z_n = z_q - atan_s;
    end else begin
      x_n = x_q + y_sh;
      y_n = y_q - x_sh;
      z_n = z_q + atan_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        load_q <= 1'b1;
        run_q  <= 1'b0;
      end else if (load_q) begin
        load_q <= 1'b0;
        run_q  <= 1'b1;
        it_q   <= '0;
      end else if (run_q) begin
        it_q <= it_q + 5'd1;
        if (it_q == 5'(CORDIC_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= deg_i * $signed({1'b0, DEG_TO_TURN});
    end
    if (load_q) begin
      x_q    <= CORDIC_K;
      y_q    <= '0;
      z_q    <= CORDIC_W'($signed(turn_f));
      flip_q <= flip_d;
    end else if (run_q) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
      if (it_q == 5'(CORDIC_STEPS - 1)) begin
        cos_q <= flip_q ? TRIG_W'(-x_n) : TRIG_W'(x_n);
        sin_q <= flip_q ? TRIG_W'(-y_n) : TRIG_W'(y_n);
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

@@ sv/spik_isqrt.sv @@
// ============================================================================
// spik_isqrt
// Truncated integer square root of a 64-bit value, one result bit per cycle.
// ============================================================================
module spik_isqrt import spik_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        run_q, done_q;
  logic [4:0]  k_q;
  logic [63:0] v_q, res_q, one_q, v_n, res_n;
  logic [64:0] trial;
  logic        ge;
  logic [31:0] root_q;

  assign trial = {1'b0, res_q} + {1'b0, one_q};
  assign ge    = {1'b0, v_q} >= trial;
  assign v_n   = ge ? v_q - trial[63:0] : v_q;
  assign res_n = ge ? (res_q >> 1) + one_q : res_q >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        k_q   <= '0;
      end else if (run_q) begin
        k_q <= k_q + 5'd1;
        if (k_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
      one_q <= 64'h4000_0000_0000_0000;
    end else if (run_q) begin
      v_q   <= v_n;
      res_q <= res_n;
      one_q <= one_q >> 2;
      if (k_q == 5'd31) root_q <= res_n[31:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ sv/stewart_platform_inverse_kinematics.sv @@
// ============================================================================
// stewart_platform_inverse_kinematics
// Six-strut Stewart platform inverse kinematics: pose in, motor step counts
// out.
// ============================================================================
// For each pose: three CORDIC runs of 30 iterations for roll, pitch and yaw,
// then per strut four reads of the joint table, six products, three squares,
// a 32-step square root and a scale product; the products and squares share
// one multiplier with the rotation matrix terms. The next pose is accepted
// while a result waits in the output register. After reset and after every
// register write the joint table is rebuilt (twelve CORDIC runs), with
// in_stall_o high.
// ============================================================================
module stewart_platform_inverse_kinematics import spik_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   pos_z_i,
  input  logic signed [24:0]   roll_deg_i,
  input  logic signed [24:0]   pitch_deg_i,
  input  logic signed [24:0]   yaw_deg_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   strut_steps_0_o,
  output logic signed [31:0]   strut_steps_1_o,
  output logic signed [31:0]   strut_steps_2_o,
  output logic signed [31:0]   strut_steps_3_o,
  output logic signed [31:0]   strut_steps_4_o,
  output logic signed [31:0]   strut_steps_5_o,
  output logic                 range_error_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  spik_state_e state_q, state_d;
  logic [3:0]         cnt_q;
  logic [STRUT_W-1:0] strut_q;
  logic               side_q;
  logic [1:0]         ang_q;

  logic [19:0]      base_radius_q, plat_radius_q;
  logic [13:0]      base_half_q, plat_half_q;
  logic [CFG_W-1:0] scale_q [3];

  logic cfg_hit, in_accept, load_out, out_valid_q;

  logic signed [POS_W-1:0]  pos_q [3];
  logic signed [ANG_W-1:0]  ang_in_q [3];
  logic signed [TRIG_W-1:0] cos_q [3];
  logic signed [TRIG_W-1:0] sin_q [3];
  logic signed [R_W-1:0]    spsr_q, r00_q, r01_q, r10_q, r11_q, r21_q, tmp_q;
  logic signed [31:0]       jx_q, jy_q, bx_q, by_q;
  logic signed [PROD_W-1:0] acc_q;
  logic signed [D_W-1:0]    d_q [3];
  logic [63:0]              sum_q;
  logic                     ovf_q, err_q;
  logic [31:0]              len_q;
  logic [31:0]              steps_q [NUM_STRUTS];
  logic [31:0]              out_steps_q [NUM_STRUTS];
  logic                     out_err_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_q, rnd_full, dot_full, dot_rnd;
  logic signed [R_W-1:0]    rnd;
  logic signed [31:0]       base_sel;
  logic signed [D_W-1:0]    d_new, d_sel, d_abs;
  logic [64:0]              sum_n;
  logic [PROD_W-1:0]        step_full;
  logic [32:0]              step_val;
  logic                     step_sat;
  logic [SCALE_W-1:0]       scale_sel;

  logic                     c_start, c_done;
  logic signed [CDEG_W-1:0] c_deg, jdeg, half_s;
  logic signed [TRIG_W-1:0] c_cos, c_sin;
  logic                     q_start, q_done;
  logic [31:0]              q_root;
  logic                     m_we;
  logic [JOINT_AW-1:0]      m_waddr, m_raddr;
  logic [31:0]              m_rdata;
  logic signed [MUL_W-1:0]  radius_s;

  spik_joint_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (rnd[31:0]),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  spik_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (c_start),
    .deg_i   (c_deg),
    .done_o  (c_done),
    .cos_o   (c_cos),
    .sin_o   (c_sin)
  );

  spik_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (q_start),
    .val_i   (sum_q),
    .done_o  (q_done),
    .root_o  (q_root)
  );

  assign cfg_hit    = cfg_we_i && (cfg_index_i < REG_IDX_W'(NUM_REGS));
  assign in_stall_o = (state_q != ST_IDLE) || cfg_we_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // ---- arithmetic helpers
  assign rnd_full = (mul_q + PROD_W'(1 << 29)) >>> 30;
  assign rnd      = rnd_full[R_W-1:0];
  assign dot_full = acc_q + mul_q;
  assign dot_rnd  = (dot_full + PROD_W'(1 << 29)) >>> 30;

  always_comb begin
    unique case (cnt_q)
      4'd2:    base_sel = bx_q;
      4'd4:    base_sel = by_q;
      default: base_sel = '0;
    endcase
  end

  assign d_new = D_W'(pos_q[cnt_q[2:1] - 2'd1]) + $signed(dot_rnd[D_W-1:0])
                 - D_W'(base_sel);
  assign d_sel = (cnt_q < 4'd3) ? d_q[cnt_q[1:0]] : '0;
  assign d_abs = d_sel[D_W-1] ? -d_sel : d_sel;
  assign sum_n = {1'b0, sum_q} + {1'b0, mul_q[63:0]};

  assign scale_sel = strut_q[0] ? scale_q[strut_q[2:1]][2*SCALE_W-1:SCALE_W]
                                : scale_q[strut_q[2:1]][SCALE_W-1:0];
  assign step_full = mul_q + PROD_W'(1 << 23);
  assign step_val  = step_full[56:24];
  assign step_sat  = ovf_q || step_val[32] || step_val[31];

  assign half_s = $signed({{(CDEG_W-22){1'b0}}, side_q ? plat_half_q : base_half_q, 8'b0});
  assign jdeg   = strut_q[0] ? pair_deg(strut_q[2:1], side_q) + half_s
                             : pair_deg(strut_q[2:1], side_q) - half_s;
  assign radius_s = $signed({{(MUL_W-28){1'b0}},
                             side_q ? plat_radius_q : base_radius_q, 8'b0});

  // ---- next state
  always_comb begin
    state_d = state_q;
    if (cfg_hit) begin
      state_d = ST_JANG;
    end else begin
      unique case (state_q)
        ST_JANG:   state_d = ST_JWAIT;
        ST_JWAIT:  if (c_done) state_d = ST_JMC;
        ST_JMC:    state_d = ST_JWC;
        ST_JWC:    state_d = ST_JWS;
        ST_JWS:    state_d = (side_q && strut_q == STRUT_W'(NUM_STRUTS - 1)) ? ST_IDLE
                                                                             : ST_JANG;
        ST_IDLE:   if (in_accept) state_d = ST_PANG;
        ST_PANG:   state_d = ST_PWAIT;
        ST_PWAIT:  if (c_done) state_d = (ang_q == 2'd2) ? ST_PMAT : ST_PANG;
        ST_PMAT:   if (cnt_q == 4'd8) state_d = ST_SRD;
        ST_SRD:    if (cnt_q == 4'd4) state_d = ST_SPROD;
        ST_SPROD:  if (cnt_q == 4'd6) state_d = ST_SSQ;
        ST_SSQ:    if (cnt_q == 4'd3) state_d = ST_SQGO;
        ST_SQGO:   state_d = ST_SQWAIT;
        ST_SQWAIT: if (q_done) state_d = ST_SCALE;
        ST_SCALE:  state_d = ST_STEP;
        ST_STEP:   state_d = (strut_q == STRUT_W'(NUM_STRUTS - 1)) ? ST_DONE : ST_SRD;
        ST_DONE:   if (load_out) state_d = ST_IDLE;
        default:   state_d = ST_JANG;
      endcase
    end
  end

  // ---- control outputs
  always_comb begin
    c_start = 1'b0;
    c_deg   = jdeg;
    q_start = 1'b0;
    m_we    = 1'b0;
    m_waddr = {strut_q, side_q, 1'b0};
    m_raddr = {strut_q, ~cnt_q[1], cnt_q[0]};
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      ST_JANG: c_start = 1'b1;
      ST_JMC: begin
        mul_a = radius_s;
        mul_b = MUL_W'(c_cos);
      end
      ST_JWC: begin
        m_we  = 1'b1;
        mul_a = radius_s;
        mul_b = MUL_W'(c_sin);
      end
      ST_JWS: begin
        m_we    = 1'b1;
        m_waddr = {strut_q, side_q, 1'b1};
      end
      ST_PANG: begin
        c_start = 1'b1;
        c_deg   = CDEG_W'(ang_in_q[ang_q]);
      end
      ST_PMAT: begin
        // roll 0, pitch 1, yaw 2
        unique case (cnt_q)
          4'd0: begin mul_a = MUL_W'(sin_q[1]); mul_b = MUL_W'(sin_q[0]); end
          4'd1: begin mul_a = MUL_W'(cos_q[2]); mul_b = MUL_W'(cos_q[1]); end
          4'd2: begin mul_a = MUL_W'(sin_q[2]); mul_b = MUL_W'(cos_q[0]); end
          4'd3: begin mul_a = MUL_W'(cos_q[2]); mul_b = MUL_W'(spsr_q);   end
          4'd4: begin mul_a = MUL_W'(sin_q[2]); mul_b = MUL_W'(cos_q[1]); end
          4'd5: begin mul_a = MUL_W'(cos_q[2]); mul_b = MUL_W'(cos_q[0]); end
          4'd6: begin mul_a = MUL_W'(sin_q[2]); mul_b = MUL_W'(spsr_q);   end
          4'd7: begin mul_a = MUL_W'(cos_q[1]); mul_b = MUL_W'(sin_q[0]); end
          default: ;
        endcase
      end
      ST_SPROD: begin
        unique case (cnt_q)
          4'd0: begin mul_a = MUL_W'(r00_q);     mul_b = MUL_W'(jx_q); end
          4'd1: begin mul_a = MUL_W'(r01_q);     mul_b = MUL_W'(jy_q); end
          4'd2: begin mul_a = MUL_W'(r10_q);     mul_b = MUL_W'(jx_q); end
          4'd3: begin mul_a = MUL_W'(r11_q);     mul_b = MUL_W'(jy_q); end
          4'd4: begin mul_a = -MUL_W'(sin_q[1]); mul_b = MUL_W'(jx_q); end
          4'd5: begin mul_a = MUL_W'(r21_q);     mul_b = MUL_W'(jy_q); end
          default: ;
        endcase
      end
      ST_SSQ: begin
        mul_a = $signed({2'b00, d_abs[31:0]});
        mul_b = $signed({2'b00, d_abs[31:0]});
      end
      ST_SQGO: q_start = 1'b1;
      ST_SCALE: begin
        mul_a = $signed({2'b00, len_q});
        mul_b = $signed({{(MUL_W-SCALE_W){1'b0}}, scale_sel});
      end
      default: ;
    endcase
  end

  // ---- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_JANG;
      cnt_q         <= '0;
      strut_q       <= '0;
      side_q        <= 1'b0;
      ang_q         <= '0;
      out_valid_q   <= 1'b0;
      base_radius_q <= BASE_RADIUS_RST;
      plat_radius_q <= PLAT_RADIUS_RST;
      base_half_q   <= HALF_ANGLE_RST;
      plat_half_q   <= HALF_ANGLE_RST;
      scale_q[0]    <= SCALE_RST;
      scale_q[1]    <= SCALE_RST;
      scale_q[2]    <= SCALE_RST;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d == state_q) ? cnt_q + 4'd1 : '0;

      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_BASE_RADIUS: base_radius_q <= cfg_data_i[19:0];
          REG_PLAT_RADIUS: plat_radius_q <= cfg_data_i[19:0];
          REG_BASE_HALF:   base_half_q   <= cfg_data_i[13:0];
          REG_PLAT_HALF:   plat_half_q   <= cfg_data_i[13:0];
          REG_SCALE_A:     scale_q[0]    <= cfg_data_i;
          REG_SCALE_B:     scale_q[1]    <= cfg_data_i;
          REG_SCALE_C:     scale_q[2]    <= cfg_data_i;
          default: ;
        endcase
      end

      if (cfg_hit) begin
        strut_q <= '0;
        side_q  <= 1'b0;
      end else begin
        unique case (state_q)
          ST_JWS: begin
            side_q <= ~side_q;
            if (side_q) strut_q <= strut_q + STRUT_W'(1);
          end
          ST_IDLE: begin
            ang_q   <= '0;
            strut_q <= '0;
          end
          ST_PWAIT: if (c_done) ang_q <= ang_q + 2'd1;
          ST_STEP:  strut_q <= strut_q + STRUT_W'(1);
          default: ;
        endcase
      end

      if (load_out)                       out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;

    if (in_accept) begin
      pos_q[0]    <= pos_to_q16(pos_x_i);
      pos_q[1]    <= pos_to_q16(pos_y_i);
      pos_q[2]    <= pos_to_q16(pos_z_i);
      ang_in_q[0] <= ang_to_q16(roll_deg_i);
      ang_in_q[1] <= ang_to_q16(pitch_deg_i);
      ang_in_q[2] <= ang_to_q16(yaw_deg_i);
      err_q       <= 1'b0;
    end

    if (state_q == ST_PWAIT && c_done) begin
      cos_q[ang_q] <= c_cos;
      sin_q[ang_q] <= c_sin;
    end

    if (state_q == ST_PMAT) begin
      unique case (cnt_q)
        4'd1: spsr_q <= rnd;
        4'd2: r00_q  <= rnd;
        4'd3: tmp_q  <= rnd;
        4'd4: r01_q  <= rnd - tmp_q;
        4'd5: r10_q  <= rnd;
        4'd6: tmp_q  <= rnd;
        4'd7: r11_q  <= rnd + tmp_q;
        4'd8: r21_q  <= rnd;
        default: ;
      endcase
    end

    if (state_q == ST_SRD) begin
      sum_q <= '0;
      ovf_q <= 1'b0;
      unique case (cnt_q)
        4'd1: jx_q <= $signed(m_rdata);
        4'd2: jy_q <= $signed(m_rdata);
        4'd3: bx_q <= $signed(m_rdata);
        4'd4: by_q <= $signed(m_rdata);
        default: ;
      endcase
    end

    if (state_q == ST_SPROD && cnt_q != 4'd0) begin
      if (cnt_q[0]) acc_q <= mul_q;
      else          d_q[cnt_q[2:1] - 2'd1] <= d_new;
    end

    if (state_q == ST_SSQ) begin
      if ((cnt_q < 4'd3 && d_abs[D_W-1:32] != '0) ||
          (cnt_q != 4'd0 && sum_n[64])) begin
        ovf_q <= 1'b1;
      end
      if (cnt_q != 4'd0) sum_q <= sum_n[63:0];
    end

    if (state_q == ST_SQWAIT && q_done) len_q <= q_root;

    if (state_q == ST_STEP) begin
      steps_q[strut_q] <= step_sat ? 32'h7FFF_FFFF : step_val[31:0];
      if (step_sat) err_q <= 1'b1;
    end

    if (load_out) begin
      out_steps_q <= steps_q;
      out_err_q   <= err_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign strut_steps_0_o = out_steps_q[0];
  assign strut_steps_1_o = out_steps_q[1];
  assign strut_steps_2_o = out_steps_q[2];
  assign strut_steps_3_o = out_steps_q[3];
  assign strut_steps_4_o = out_steps_q[4];
  assign strut_steps_5_o = out_steps_q[5];
  assign range_error_o   = out_err_q;

endmodule

@@ tb/sv/tb_stewart_platform_inverse_kinematics.sv @@
// ============================================================================
// tb_stewart_platform_inverse_kinematics
// Drives random and corner-case poses through the Stewart platform inverse
// kinematics block under several geometry settings and checks each set of
// step counts against a bit-accurate behavioral predictor.
// ============================================================================
module tb_stewart_platform_inverse_kinematics import spik_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] steps [NUM_STRUTS];
    logic               rerr;
  } leg_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [24:0] roll_deg_i = '0, pitch_deg_i = '0, yaw_deg_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] strut_steps_0_o, strut_steps_1_o, strut_steps_2_o;
  logic signed [31:0] strut_steps_3_o, strut_steps_4_o, strut_steps_5_o;
  logic               range_error_o;
  logic               cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]   cfg_data_i = '0;

  stewart_platform_inverse_kinematics DUT (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [47:0]        geo_reg [NUM_REGS];
  longint             joint_tab [4*NUM_STRUTS];
  leg_result_t        pending_q [$];
  int                 err_cnt = 0;
  bit                 stall_on = 1'b1;

  localparam logic [31:0] ATAN_TAB [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

  function automatic longint rnd30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void trig(longint deg16, output longint c, output longint s);
    logic [63:0] p;
    logic [31:0] ang;
    bit          flip;
    longint      x, y, z, nx;
    p = 64'(deg16) * 64'(DEG_TO_TURN) + (64'd1 << 23);
    ang = p[55:24];
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang - 32'h80000000;
    z = longint'($signed(ang));
    x = CORDIC_K;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_TAB[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void rebuild_joints();
    longint rb, rp, hb, hp, c, s, ab, ap, sg, ctr;
    rb = longint'(geo_reg[REG_BASE_RADIUS]) <<< 8;
    rp = longint'(geo_reg[REG_PLAT_RADIUS]) <<< 8;
    hb = longint'(geo_reg[REG_BASE_HALF]) <<< 8;
    hp = longint'(geo_reg[REG_PLAT_HALF]) <<< 8;
    for (int i = 0; i < NUM_STRUTS; i++) begin
      sg = (i & 1) ? 1 : -1;
      ctr = 120 * (i >> 1);
      ab = ctr * 65536 + sg * hb;
      ap = (ctr + 60) * 65536 + sg * hp;
      trig(ab, c, s);
      joint_tab[4*i]   = longint'($signed(32'(rnd30(rb, c))));
      joint_tab[4*i+1] = longint'($signed(32'(rnd30(rb, s))));
      trig(ap, c, s);
      joint_tab[4*i+2] = longint'($signed(32'(rnd30(rp, c))));
      joint_tab[4*i+3] = longint'($signed(32'(rnd30(rp, s))));
    end
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > v) one >>= 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v -= res + one; res = (res >> 1) + one;
      end else res >>= 1;
      one >>= 2;
    end
    return res;
  endfunction

  function automatic bit sum_sq(ref logic [63:0] acc, input longint d);
    logic [63:0] m, sq;
    m = d < 0 ? 64'(-d) : 64'(d);
    if (m > 64'hFFFFFFFF) return 1'b0;
    sq = m * m;
    if (acc > ~sq) return 1'b0;
    acc += sq;
    return 1'b1;
  endfunction

  function automatic leg_result_t solve_pose(logic signed [31:0] x, y, zz,
                                              logic signed [24:0] ro, pi, ya);
    leg_result_t r;
    longint cr, sr, cp, sp, cy, sy, spsr, r00, r01, r10, r11, r20, r21;
    longint jx, jy, dx, dy, dz, hf;
    logic [63:0] acc, len, scl, st;
    trig(longint'(ang_to_q16(ro)), cr, sr);
    trig(longint'(ang_to_q16(pi)), cp, sp);
    trig(longint'(ang_to_q16(ya)), cy, sy);
    spsr = rnd30(sp, sr);
    r00 = rnd30(cy, cp);
    r01 = rnd30(cy, spsr) - rnd30(sy, cr);
    r10 = rnd30(sy, cp);
    r11 = rnd30(sy, spsr) + rnd30(cy, cr);
    r20 = -sp;
    r21 = rnd30(cp, sr);
    hf = 64'sd1 <<< 29;
    r.rerr = 1'b0;
    for (int i = 0; i < NUM_STRUTS; i++) begin
      jx = joint_tab[4*i+2];
      jy = joint_tab[4*i+3];
      dx = longint'(pos_to_q16(x)) + ((r00*jx + r01*jy + hf) >>> 30) - joint_tab[4*i];
      dy = longint'(pos_to_q16(y)) + ((r10*jx + r11*jy + hf) >>> 30) - joint_tab[4*i+1];
      dz = longint'(pos_to_q16(zz)) + ((r20*jx + r21*jy + hf) >>> 30);
      scl = (geo_reg[REG_SCALE_A + (i >> 1)] >> (24 * (i & 1))) & 64'hFFFFFF;
      acc = 0;
      if (!sum_sq(acc, dx) || !sum_sq(acc, dy) || !sum_sq(acc, dz)) begin
        st = 64'h7FFFFFFF; r.rerr = 1'b1;
      end else begin
        len = int_sqrt(acc);
        st = (len * scl + (64'd1 << 23)) >> 24;
        if (st > 64'h7FFFFFFF) begin
          st = 64'h7FFFFFFF; r.rerr = 1'b1;
        end
      end
      r.steps[i] = st[31:0];
    end
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // valid stays high after acceptance only until the next step drives the next
  // transaction or drops it
  task automatic send_pose(logic signed [31:0] x, y, zz, logic signed [24:0] ro, pi, ya);
    int g;
    g = stall_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x; pos_y_i <= y; pos_z_i <= zz;
    roll_deg_i <= ro; pitch_deg_i <= pi; yaw_deg_i <= ya;
    pending_q.push_back(solve_pose(x, y, zz, ro, pi, ya));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    geo_reg[idx] = val;
    @(posedge clk_i);
    rebuild_joints();
  endtask

  function automatic logic signed [24:0] rnd_ang();
    case ($urandom_range(0, 3))
      0: return 25'($signed($urandom_range(0, 23592960)) - 11796480);
      1: return 25'($signed($urandom_range(0, 5898240)) - 2949120);
      2: return $urandom_range(0, 1) ? 25'sd11796480 : -25'sd11796480;
      default: return 25'($signed($urandom_range(0, 1310720)) - 655360);
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_pos();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h01000000)) - 32'sh00800000);
      default: return 32'($signed($urandom_range(0, 32'h00C80000)) - 32'sh00640000);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] mx, mn;
    logic signed [24:0] am;
    mx = 32'sh7FFFFFFF; mn = 32'sh80000000; am = 25'sd11796480;
    send_pose(0, 0, 0, 0, 0, 0);
    send_pose(0, 0, 32'sd13107200, 0, 0, 0);
    send_pose(mx, mx, mx, am, am, am);
    send_pose(mn, mn, mn, -am, -am, -am);
    send_pose(mx, 0, 0, 0, 0, 0);
    send_pose(0, mn, 0, 0, 0, 0);
    send_pose(0, 0, 32'sd6553600, 25'sd5898240, 0, 0);
    send_pose(0, 0, 32'sd6553600, 0, 25'sd5898240, 0);
    send_pose(0, 0, 32'sd6553600, 0, 0, 25'sd5898240);
    send_pose(0, 0, 32'sd6553600, 25'sd11796480, 0, 0);  // half turn
    send_pose(0, 0, 32'sd6553600, 25'sd2949120, -25'sd1966080, 25'sd983040);
    send_pose(32'sd655360, -32'sd655360, 32'sd9830400, -25'sd1, 25'sd1, 25'sd16777215);
    send_pose(-32'sd1, 32'sd1, mx, 0, 0, 0);
    drain();
  endtask

  task automatic test_geometry(logic [47:0] rb, rp, hb, hp, sa, sb, sc, int n);
    write_reg(REG_BASE_RADIUS, rb);
    write_reg(REG_PLAT_RADIUS, rp);
    write_reg(REG_BASE_HALF, hb);
    write_reg(REG_PLAT_HALF, hp);
    write_reg(REG_SCALE_A, sa);
    write_reg(REG_SCALE_B, sb);
    write_reg(REG_SCALE_C, sc);
    cfg_we_i <= 1'b0;
    for (int k = 0; k < n; k++)
      send_pose(rnd_pos(), rnd_pos(), rnd_pos(), rnd_ang(), rnd_ang(), rnd_ang());
    drain();
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) stall_on = 1'b0;
      send_pose(rnd_pos(), rnd_pos(), rnd_pos(), rnd_ang(), rnd_ang(), rnd_ang());
    end
    stall_on = 1'b1;
    drain();
  endtask

  // Output side: random stall, compare each transaction
  always @(posedge clk_i) begin
    leg_result_t e;
    logic signed [31:0] got [NUM_STRUTS];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{strut_steps_0_o, strut_steps_1_o, strut_steps_2_o,
              strut_steps_3_o, strut_steps_4_o, strut_steps_5_o};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transaction", $time);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        for (int i = 0; i < NUM_STRUTS; i++)
          if (got[i] !== e.steps[i]) begin
            $display("%0t: strut %0d expected %0d actual %0d", $time, i, e.steps[i], got[i]);
            err_cnt++;
          end
        if (range_error_o !== e.rerr) begin
          $display("%0t: range_error expected %0b actual %0b", $time, e.rerr, range_error_o);
          err_cnt++;
        end
      end
    end
    out_stall_i <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b0;
  end

  initial begin
    geo_reg[REG_BASE_RADIUS] = BASE_RADIUS_RST;
    geo_reg[REG_PLAT_RADIUS] = PLAT_RADIUS_RST;
    geo_reg[REG_BASE_HALF] = HALF_ANGLE_RST;
    geo_reg[REG_PLAT_HALF] = HALF_ANGLE_RST;
    geo_reg[REG_SCALE_A] = SCALE_RST;
    geo_reg[REG_SCALE_B] = SCALE_RST;
    geo_reg[REG_SCALE_C] = SCALE_RST;
    rebuild_joints();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400);
    test_geometry(48'hFFFFF, 48'hFFFFF, 48'h3FFF, 48'h3FFF,
                  48'hFFFFFFFFFFFF, 48'hFFFFFF000000, 48'h000000FFFFFF, 60);
    test_geometry(0, 0, 0, 0, 0, 48'h000100000100, 48'h123456ABCDEF, 60);
    test_geometry(48'd51200, 48'd12800, 48'd7680, 48'd1280,
                  48'h000800000400, 48'h000200000A00, 48'h001000000080, 100);
    test_geometry(BASE_RADIUS_RST, PLAT_RADIUS_RST, HALF_ANGLE_RST, HALF_ANGLE_RST,
                  SCALE_RST, SCALE_RST, SCALE_RST, 120);
    if (err_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
sv/spik_pkg.sv
sv/spik_joint_mem.sv
sv/spik_cordic.sv
sv/spik_isqrt.sv
sv/stewart_platform_inverse_kinematics.sv
tb/sv/tb_stewart_platform_inverse_kinematics.sv
